// File: rtl/ins_pkg.sv
// ----------------------------------------------------------------------------
// ins_pkg
// Shared types and constants of the insertion sorter.
// ----------------------------------------------------------------------------
package ins_pkg;

    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic signed [VALUE_BITS-1:0] t_val;

    typedef struct packed {
        t_val value;
        logic batch_end;
    } t_in_word;

    typedef struct packed {
        t_val sorted_value;
        logic run_end;
        logic overflow;
    } t_out_word;

    // one write port and one registered read port of the entry store
    typedef struct packed {
        logic wr_en;
        t_idx wr_addr;
        t_val wr_data;
        logic rd_en;
        t_idx rd_addr;
    } t_mem_req;

endpackage

// File: rtl/ins_cmp.sv
// ----------------------------------------------------------------------------
// ins_cmp
// Shared signed two's-complement compare used by the compare step of each insertion.
// ----------------------------------------------------------------------------
module ins_cmp (
    input  ins_pkg::t_val i_a,
    input  ins_pkg::t_val i_b,
    output logic          o_gt
);

    assign o_gt = (i_a > i_b);

endmodule

// File: rtl/ins_store.sv
// ----------------------------------------------------------------------------
// ins_store
// Entry store of the sorted list: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ins_store (
    input  logic             i_clk,
    input  ins_pkg::t_mem_req i_req,
    output ins_pkg::t_val    o_rd_data
);

    ins_pkg::t_val r_mem [ins_pkg::CAPACITY];
    ins_pkg::t_val r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        // hold read data until the next read
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/insertion_sorter_core.sv
// Insert: an item is written or dropped on acceptance if the store is empty or full;
//   otherwise each larger entry is read, compared and shifted up before the item is placed.
// Throughput: one item at a time; the compare/shift loop over the store sets the rate.
// Emit: after the batch end item, the first entry is read, then one word per cycle unless stalled.
// Reset: synchronous, active low; clears state, fill count, overflow flag and output valid.
// ----------------------------------------------------------------------------
// insertion_sorter_core
// Stable insertion sort of one batch of signed values, emitted smallest first.
// ----------------------------------------------------------------------------
module insertion_sorter_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ins_pkg::t_in_word i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ins_pkg::t_out_word o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_PLACE,
        S_EMIT_RD,
        S_EMIT_WR
    } t_state;

    t_state              r_state, n_state;
    ins_pkg::t_cnt       r_fill, n_fill;
    logic                r_drop, n_drop;
    ins_pkg::t_idx       r_pos, n_pos;
    ins_pkg::t_idx       r_k, n_k;
    ins_pkg::t_val       r_v, n_v;
    logic                r_last, n_last;
    logic                r_o_valid, n_o_valid;
    ins_pkg::t_out_word  r_o_data, n_o_data;

    ins_pkg::t_mem_req   mem_req;
    ins_pkg::t_val       rd_data;
    logic                gt;
    logic                accept;
    logic                slot_free;
    logic                is_final;

    ins_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    ins_cmp u_cmp (
        .i_a  (rd_data),
        .i_b  (r_v),
        .o_gt (gt)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign slot_free   = !r_o_valid || !i_out_stall;
    assign is_final    = ((ins_pkg::t_cnt'(r_k) + ins_pkg::t_cnt'(1)) == r_fill);
    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_drop    = r_drop;
        n_pos     = r_pos;
        n_k       = r_k;
        n_v       = r_v;
        n_last    = r_last;
        n_o_data  = r_o_data;
        n_o_valid = r_o_valid && i_out_stall;

        mem_req         = '0;
        mem_req.wr_data = r_v;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_v    = i_in_data.value;
                    n_last = i_in_data.batch_end;
                    n_k    = '0;
                    if (r_fill == ins_pkg::t_cnt'(ins_pkg::CAPACITY)) begin
                        // full: drop the word
                        n_drop  = 1'b1;
                        n_state = i_in_data.batch_end ? S_EMIT_RD : S_IDLE;
                    end else if (r_fill == '0) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = '0;
                        mem_req.wr_data = i_in_data.value;
                        n_fill          = ins_pkg::t_cnt'(1);
                        n_state         = i_in_data.batch_end ? S_EMIT_RD : S_IDLE;
                    end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = ins_pkg::t_idx'(r_fill - ins_pkg::t_cnt'(1));
                        n_pos           = ins_pkg::t_idx'(r_fill);
                        n_state         = S_CMP;
                    end
                end
            end
            S_CMP: begin
                // rd_data holds the entry just below r_pos
                if (gt) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = r_pos;
                    mem_req.wr_data = rd_data;
                    n_pos           = r_pos - ins_pkg::t_idx'(1);
                    if (r_pos == ins_pkg::t_idx'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = r_pos - ins_pkg::t_idx'(2);
                    end
                end else begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = r_pos;
                    n_fill          = r_fill + ins_pkg::t_cnt'(1);
                    n_state         = r_last ? S_EMIT_RD : S_IDLE;
                end
            end
            S_PLACE: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_pos;
                n_fill          = r_fill + ins_pkg::t_cnt'(1);
                n_state         = r_last ? S_EMIT_RD : S_IDLE;
            end
            S_EMIT_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = r_k;
                n_state         = S_EMIT_WR;
            end
            S_EMIT_WR: begin
                if (slot_free) begin
                    n_o_valid             = 1'b1;
                    n_o_data.sorted_value = rd_data;
                    n_o_data.run_end      = is_final;
                    n_o_data.overflow     = r_drop;
                    if (is_final) begin
                        n_fill  = '0;
                        n_drop  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        // advance to the next entry
                        n_k             = r_k + ins_pkg::t_idx'(1);
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = r_k + ins_pkg::t_idx'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_drop    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_drop    <= n_drop;
            r_o_valid <= n_o_valid;
        end
        r_pos    <= n_pos;
        r_k      <= n_k;
        r_v      <= n_v;
        r_last   <= n_last;
        r_o_data <= n_o_data;
    end

endmodule
